FILE: hw/rtl/pst_pkg.sv
// Shared types and constants for the pass schedule table.
// Holds the request and result payloads, the mode and status codes and the
// command and status groups between the controller and the datapath.
`timescale 1ns / 1ps

package pst_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int READ_MAX_DEF    = 16;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_SCHED = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NONE = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] pass_time;
		logic [15:0] pass_length;
		logic [31:0] now_seconds;
		logic [4:0]  read_count;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] wait_seconds;
		logic [15:0] window_length;
		logic [31:0] out_time;
		logic [4:0]  out_count;
		logic        last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic add;
		logic walk_rd;
		logic walk_chk;
		logic emit_none;
		logic load_cnt;
		logic emit_empty;
		logic rd_issue;
		logic rd_emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       ptr_at_fill;
		logic       skip;
		logic       cnt_zero;
		logic       rd_last;
	} dp_stat_t;

endpackage

FILE: hw/rtl/pst_datapath.sv
// Datapath of the pass schedule table: the two pass stores, fill count,
// read pointer, read-out counters and the result register.
// Depends on pst_pkg.
`timescale 1ns / 1ps

module pst_datapath #(
	parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF,
	parameter int READ_MAX    = pst_pkg::READ_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pst_pkg::request_t  request,
	input  pst_pkg::ctrl_cmd_t cmd,
	output pst_pkg::dp_stat_t  stat,
	output logic               valid,
	output pst_pkg::result_t   result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = (CW > 7) ? CW : 7;

	logic [31:0] start_mem  [TABLE_DEPTH];
	logic [15:0] length_mem [TABLE_DEPTH];

	pst_pkg::request_t req_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     ptr_q;
	logic [31:0]       rd_time_q;
	logic [15:0]       rd_len_q;
	logic [4:0]        cnt_q;
	logic [4:0]        idx_q;
	logic              valid_q;
	pst_pkg::result_t  res_q;

	logic              full;
	logic [CW-1:0]     avail;
	logic [NW-1:0]     n_a;
	logic [NW-1:0]     n_b;
	logic [4:0]        n_next;
	logic [CW-1:0]     rd_sum;
	logic [AW-1:0]     rd_addr;
	logic              rd_en;
	logic [32:0]       diff;
	logic              skip;
	pst_pkg::result_t  res_d;

	assign full  = (fill_q == CW'(TABLE_DEPTH));
	assign avail = fill_q - ptr_q;

	// Read-out length: the request clipped to the maximum and to what is left.
	always_comb begin
		n_a = NW'(req_q.read_count);
		if (n_a > NW'(READ_MAX)) begin
			n_a = NW'(READ_MAX);
		end
		n_b = NW'(avail);
		if (n_a > n_b) begin
			n_a = n_b;
		end
		n_next = n_a[4:0];
	end

	assign rd_sum  = ptr_q + CW'(idx_q);
	assign rd_addr = cmd.walk_rd ? ptr_q[AW-1:0] : rd_sum[AW-1:0];
	assign rd_en   = cmd.walk_rd | cmd.rd_issue;

	// One subtraction gives both the started test and the wait.
	assign diff = {1'b0, rd_time_q} - {1'b0, req_q.now_seconds};
	assign skip = diff[32] | (diff[31:0] == 32'd0);

	assign stat.mode        = req_q.mode;
	assign stat.ptr_at_fill = (ptr_q == fill_q);
	assign stat.skip        = skip;
	assign stat.cnt_zero    = (cnt_q == 5'd0);
	assign stat.rd_last     = ((idx_q + 5'd1) == cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.add && !full) begin
			start_mem[fill_q[AW-1:0]]  <= req_q.pass_time;
			length_mem[fill_q[AW-1:0]] <= req_q.pass_length;
		end
		if (rd_en) begin
			rd_time_q <= start_mem[rd_addr];
			rd_len_q  <= length_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= request;
		end
		if (cmd.load_cnt) begin
			cnt_q <= n_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ptr_q   <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.add | cmd.emit_none | cmd.emit_empty | cmd.rd_emit |
				(cmd.walk_chk & ~skip);
			if (cmd.add && !full) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.walk_chk && skip) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.load_cnt) begin
				idx_q <= '0;
			end else if (cmd.rd_emit) begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		if (cmd.add) begin
			res_d.status = full ? pst_pkg::STAT_FULL : pst_pkg::STAT_OK;
		end else if (cmd.emit_none) begin
			res_d.status = pst_pkg::STAT_NONE;
		end else if (cmd.walk_chk) begin
			res_d.wait_seconds  = diff[31:0];
			res_d.window_length = rd_len_q;
		end else if (cmd.rd_emit) begin
			res_d.out_time  = rd_time_q;
			res_d.out_count = cnt_q;
			res_d.last      = stat.rd_last;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign valid  = valid_q;
	assign result = res_q;

endmodule

FILE: hw/rtl/pst_ctrl.sv
// Controller state machine of the pass schedule table.
// Sequences the datapath through add, schedule walk and read-out. Depends on pst_pkg.
`timescale 1ns / 1ps

module pst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pst_pkg::dp_stat_t  stat,
	output logic               busy,
	output pst_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_WALK_RD  = 3'd2;
	localparam logic [2:0] S_WALK_CHK = 3'd3;
	localparam logic [2:0] S_RD_RD    = 3'd4;
	localparam logic [2:0] S_RD_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.mode)
					pst_pkg::MODE_ADD: begin
						cmd.add = 1'b1;
						state_d = S_IDLE;
					end
					pst_pkg::MODE_SCHED: begin
						state_d = S_WALK_RD;
					end
					pst_pkg::MODE_READ: begin
						cmd.load_cnt = 1'b1;
						state_d      = S_RD_RD;
					end
					default: begin
						cmd.emit_empty = 1'b1;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_WALK_RD: begin
				if (stat.ptr_at_fill) begin
					cmd.emit_none = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				cmd.walk_chk = 1'b1;
				state_d      = stat.skip ? S_WALK_RD : S_IDLE;
			end
			S_RD_RD: begin
				if (stat.cnt_zero) begin
					cmd.emit_empty = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d      = S_RD_EMIT;
				end
			end
			S_RD_EMIT: begin
				cmd.rd_emit = 1'b1;
				state_d     = stat.rd_last ? S_IDLE : S_RD_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/pass_schedule_table.sv
// Pass schedule table. Add and unused-mode requests are answered from the dispatch state, an
// empty read-out from the read state after it. A schedule walk takes a read and a check
// state per pass, skipping passes already started, and answers from a check state, or from
// the read state when none is left. A read-out reads, then emits, each start time in turn.
// A new request is taken in the cycle the final result is shown; results cannot be stalled.
// Reset clears the fill count, the read pointer and the controller; the stores are not cleared.
`timescale 1ns / 1ps

module pass_schedule_table #(
	parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF,
	parameter int READ_MAX    = pst_pkg::READ_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pst_pkg::request_t request,
	output logic              valid,
	output pst_pkg::result_t  result
);

	// The controller owns sequencing only; every piece of storage and
	// arithmetic sits in the datapath, and the two talk through the command
	// and status groups below.
	pst_pkg::ctrl_cmd_t cmd;
	pst_pkg::dp_stat_t  stat;

	pst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath latches the request on acceptance, so the request port
	// need not hold its value while the block is busy.
	pst_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.READ_MAX    (READ_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.valid   (valid),
		.result  (result)
	);

	// An accepted request occupies the block, and its first result cannot
	// come out in the very next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !valid))
		else $error("accepted request did not occupy the block");

	// The final result of a request always finds the block free again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && result.last) |-> !busy)
		else $error("block still busy after the final result");

	// Within a read-out another start time always follows one that is not the last.
	a_stream_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !result.last) |-> ##2 valid)
		else $error("read-out result missing");

	// A read-out result that is not the last one never comes with the block idle.
	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !result.last) |-> busy)
		else $error("block left the read-out early");

endmodule

FILE: tb/pass_schedule_checker.sv
// Checker for the pass schedule table: watches the request and result channels,
// predicts every result from its own copy of the table and compares field by field.
// Depends on pst_pkg for the payload types, the mode codes and the status codes.
`timescale 1ns / 1ps

module pass_schedule_checker #(
	parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF,
	parameter int READ_MAX    = pst_pkg::READ_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  pst_pkg::request_t request,
	input  logic              valid,
	input  pst_pkg::result_t  result,
	output int unsigned       fail_count,
	output int unsigned       outstanding,
	output int unsigned       checked
);

	localparam int PRINT_LIMIT = 40;

	logic [31:0]      pass_start [TABLE_DEPTH];
	logic [15:0]      pass_window [TABLE_DEPTH];
	int unsigned      passes_stored;
	int unsigned      next_pass;
	pst_pkg::result_t results_due [$];

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t ns: %s", $time / 1000, what);
	endtask

	task automatic predict_request(input pst_pkg::request_t req);
		pst_pkg::result_t res;
		int unsigned      n;

		res = '0;
		res.last = 1'b1;
		case (req.mode)
			pst_pkg::MODE_ADD: begin
				if (passes_stored >= TABLE_DEPTH) begin
					res.status = pst_pkg::STAT_FULL;
				end else begin
					pass_start[passes_stored] = req.pass_time;
					pass_window[passes_stored] = req.pass_length;
					passes_stored++;
				end
				results_due.push_back(res);
			end
			pst_pkg::MODE_SCHED: begin
				// A pass starting exactly now counts as started.
				while (next_pass < passes_stored && pass_start[next_pass] <= req.now_seconds)
					next_pass++;
				if (next_pass >= passes_stored) begin
					res.status = pst_pkg::STAT_NONE;
				end else begin
					res.wait_seconds = pass_start[next_pass] - req.now_seconds;
					res.window_length = pass_window[next_pass];
				end
				results_due.push_back(res);
			end
			pst_pkg::MODE_READ: begin
				n = req.read_count;
				if (n > READ_MAX)
					n = READ_MAX;
				if (n > passes_stored - next_pass)
					n = passes_stored - next_pass;
				if (n == 0) begin
					results_due.push_back(res);
				end else begin
					for (int unsigned i = 0; i < n; i++) begin
						res.out_time = pass_start[next_pass + i];
						res.out_count = 5'(n);
						res.last = (i + 1 == n);
						results_due.push_back(res);
					end
				end
			end
			default: begin
				results_due.push_back(res);
			end
		endcase
	endtask

	task automatic check_result(input pst_pkg::result_t got);
		pst_pkg::result_t want;

		if (results_due.size() == 0) begin
			report_mismatch($sformatf("result with nothing outstanding: status %0d time %0h last %0b",
				got.status, got.out_time, got.last));
			return;
		end
		want = results_due.pop_front();
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0d, expected %0d", got.status, want.status));
		if (got.wait_seconds !== want.wait_seconds)
			report_mismatch($sformatf("wait_seconds got %0h, expected %0h",
				got.wait_seconds, want.wait_seconds));
		if (got.window_length !== want.window_length)
			report_mismatch($sformatf("window_length got %0h, expected %0h",
				got.window_length, want.window_length));
		if (got.out_time !== want.out_time)
			report_mismatch($sformatf("out_time got %0h, expected %0h", got.out_time, want.out_time));
		if (got.out_count !== want.out_count)
			report_mismatch($sformatf("out_count got %0d, expected %0d",
				got.out_count, want.out_count));
		if (got.last !== want.last)
			report_mismatch($sformatf("last got %0b, expected %0b", got.last, want.last));
	endtask

	// Results are handled before a new request, since the block may take the next
	// request in the cycle that shows the final result of the previous one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passes_stored = 0;
			next_pass = 0;
			results_due.delete();
			fail_count = 0;
			outstanding = 0;
			checked = 0;
		end else begin
			if (valid === 1'b1) begin
				check_result(result);
				checked++;
			end else if (valid !== 1'b0) begin
				report_mismatch("result strobe is unknown");
			end
			if (start === 1'b1 && busy === 1'b0)
				predict_request(request);
			outstanding = results_due.size();
		end
	end

endmodule

FILE: tb/pass_schedule_table_tb.sv
// Top of the pass schedule table testbench: clock, reset, request stimulus and verdict.
// Depends on pst_pkg, the pass_schedule_table block and pass_schedule_checker.
`timescale 1ns / 1ps

module pass_schedule_table_tb;

	localparam int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF;
	localparam int READ_MAX    = pst_pkg::READ_MAX_DEF;

	// The block has no name for the fourth mode; it must answer it with an empty result.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int RANDOM_REQUESTS = 24;
	// The slowest request is a schedule walking the whole table, a read and a check state per pass,
	// and the longest gap between requests is the longest pause drawn. The limit is well above both.
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 20;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	pst_pkg::request_t request;
	logic              valid;
	pst_pkg::result_t  result;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned checked;
	int unsigned idle_cycles;

	// Stimulus bookkeeping only: how full the table is and which start times went in,
	// so that well-formed sequences can be built. It plays no part in the checking.
	int unsigned n_add;
	int unsigned n_refused;
	int unsigned n_sched;
	int unsigned n_read;
	int unsigned n_unused;
	int unsigned stored;
	logic [31:0] tail_time;
	logic [31:0] sim_now;
	logic [31:0] added_times [$];
	bit          back_to_back;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	pass_schedule_table u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.valid   (valid),
		.result  (result)
	);

	pass_schedule_checker #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.READ_MAX    (READ_MAX)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.valid       (valid),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// The watchdog counts cycles in which neither a request nor a result is accepted.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || valid === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Every field but the mode is filled with random bits; the fields the mode does not use stay so.
	function automatic pst_pkg::request_t scrambled(input logic [1:0] mode);
		pst_pkg::request_t req;

		req.mode = mode;
		req.pass_time = $urandom;
		req.pass_length = 16'($urandom);
		req.now_seconds = $urandom;
		req.read_count = 5'($urandom);
		return req;
	endfunction

	function automatic logic [15:0] pick_length();
		int unsigned pick;

		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 16'h0000;
		if (pick == 1)
			return 16'hffff;
		return 16'($urandom);
	endfunction

	// Drives one request from a rising edge and returns at the edge that accepts it.
	task automatic issue(input pst_pkg::request_t req);
		start <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		case (req.mode)
			pst_pkg::MODE_ADD: begin
				n_add++;
				if (stored < TABLE_DEPTH) begin
					stored++;
					added_times.push_back(req.pass_time);
				end else begin
					n_refused++;
				end
			end
			pst_pkg::MODE_SCHED: n_sched++;
			pst_pkg::MODE_READ:  n_read++;
			default:             n_unused++;
		endcase
	endtask

	// Mostly short gaps, a few long ones, and stretches of requests back to back.
	task automatic pause();
		int unsigned pick;
		int unsigned gap;

		if ($urandom_range(0, 29) == 0)
			back_to_back = !back_to_back;
		pick = $urandom_range(0, 99);
		if (back_to_back || pick < 50)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap != 0) begin
			start <= 1'b0;
			request <= scrambled(2'($urandom));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_pass(input logic [31:0] pass_time, input logic [15:0] pass_length);
		pst_pkg::request_t req;

		req = scrambled(pst_pkg::MODE_ADD);
		req.pass_time = pass_time;
		req.pass_length = pass_length;
		issue(req);
		pause();
	endtask

	task automatic ask_next_pass(input logic [31:0] now_seconds);
		pst_pkg::request_t req;

		req = scrambled(pst_pkg::MODE_SCHED);
		req.now_seconds = now_seconds;
		issue(req);
		pause();
	endtask

	task automatic read_starts(input logic [4:0] read_count);
		pst_pkg::request_t req;

		req = scrambled(pst_pkg::MODE_READ);
		req.read_count = read_count;
		issue(req);
		pause();
	endtask

	// Most passes follow the previous one in time, as a real pass list would. A few
	// share the previous start time, and a few land anywhere, out of order.
	task automatic random_add();
		int unsigned pick;
		logic [31:0] when;

		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			tail_time = tail_time + $urandom_range(1, 60);
			when = tail_time;
		end else if (pick < 92) begin
			when = tail_time;
		end else begin
			when = $urandom;
		end
		add_pass(when, pick_length());
	endtask

	// The time mostly creeps forward more slowly than the passes are added, so the
	// read pointer lags behind the fill count and read-outs get clipped. Now and then
	// the time lands exactly on a stored start, catches up, or jumps anywhere.
	task automatic random_schedule();
		int unsigned pick;
		logic [31:0] now_seconds;

		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			sim_now = sim_now + $urandom_range(0, 30);
			now_seconds = sim_now;
		end else if (pick < 80 && added_times.size() != 0) begin
			now_seconds = added_times[$urandom_range(0, added_times.size() - 1)];
		end else if (pick < 88) begin
			sim_now = tail_time + $urandom_range(0, 20);
			now_seconds = sim_now;
		end else if (pick < 96) begin
			now_seconds = $urandom;
		end else begin
			now_seconds = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
		end
		ask_next_pass(now_seconds);
	endtask

	task automatic random_read();
		int unsigned pick;

		pick = $urandom_range(0, 99);
		if (pick < 10)
			read_starts(5'd0);
		else if (pick < 25)
			read_starts(5'(READ_MAX));
		else if (pick < 40)
			read_starts(5'($urandom_range(READ_MAX + 1, 31)));
		else
			read_starts(5'($urandom_range(1, READ_MAX)));
	endtask

	initial begin
		int unsigned counted;
		int unsigned pick;

		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		n_add = 0;
		n_refused = 0;
		n_sched = 0;
		n_read = 0;
		n_unused = 0;
		stored = 0;
		tail_time = 32'd500;
		sim_now = 32'd250;
		back_to_back = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An empty table answers an empty read-out and no pass left,
		// and the unused mode gets an empty result whatever its fields hold.
		read_starts(5'(READ_MAX));
		ask_next_pass(32'd0);
		issue('{mode: MODE_UNUSED, pass_time: 32'hffff_ffff, pass_length: 16'hffff,
			now_seconds: 32'hffff_ffff, read_count: 5'h1f});
		pause();
		// Passes at the extremes of time and window length.
		add_pass(32'd0, 16'h0000);
		add_pass(32'd100, 16'hffff);
		add_pass(32'd200, 16'h1234);
		add_pass(32'hffff_ffff, 16'd7);
		// A read-out asking for more than is stored, then nothing, then part.
		read_starts(5'h1f);
		read_starts(5'd0);
		read_starts(5'd2);
		// Passes starting exactly now are skipped, including one at the last second.
		ask_next_pass(32'd0);
		ask_next_pass(32'd100);
		ask_next_pass(32'hffff_fffe);
		ask_next_pass(32'hffff_ffff);
		// The pointer now sits at the fill count before any walk starts.
		ask_next_pass(32'd0);
		read_starts(5'd5);
		add_pass(32'd300, 16'd1);
		add_pass(32'd400, 16'd2);
		add_pass(32'd500, 16'd3);
		read_starts(5'h1f);
		ask_next_pass(32'd250);

		// Random part: mostly adds and schedules in a sensible order, with read-outs
		// and the odd unused-mode request mixed in.
		counted = 0;
		while (counted < RANDOM_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				random_add();
				counted++;
			end else if (pick < 70) begin
				random_schedule();
				counted++;
			end else if (pick < 95) begin
				random_read();
				counted++;
			end else begin
				issue(scrambled(MODE_UNUSED));
				pause();
			end
		end

		// Fill the table to the brim, then knock on it while it is full.
		while (stored < TABLE_DEPTH) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				random_schedule();
			else if (pick == 1)
				random_read();
			else
				random_add();
		end
		repeat (3) add_pass($urandom, pick_length());
		read_starts(5'h1f);
		ask_next_pass(32'hffff_fffe);
		read_starts(5'(READ_MAX));
		ask_next_pass(32'hffff_ffff);
		read_starts(5'(READ_MAX));
		ask_next_pass(32'd0);
		start <= 1'b0;

		// Wait for every outstanding result, then a little longer to catch strays.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d adds (%0d refused with the table full), %0d schedules, ",
			n_add, n_refused, n_sched);
		$display("  %0d read-outs and %0d unused-mode requests; %0d results checked",
			n_read, n_unused, checked);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
